FILE: rtl/core/itdh_pkg.sv
// Shared types, constants and helper functions of the integer-to-text converter.
// Used by itdh_front, itdh_back and integer_to_text_dec_hex; no dependencies.
package itdh_pkg;

   localparam int VALUE_W     = 64;
   localparam int NUM_DIGITS  = 20;
   localparam int DIGITS_W    = 4 * NUM_DIGITS;
   localparam int BITS_PER_CY = 2;
   localparam int DABBLE_CY   = VALUE_W / BITS_PER_CY;
   localparam int CNT_W       = 5;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_X    = 8'h78;
   localparam logic [7:0] CHAR_A    = 8'h41;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               hex;
      logic               prefix;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DABBLE,
      ST_SKIP,
      ST_PREFIX0,
      ST_PREFIXX,
      ST_EMIT
   } state_type;

   // add 3 to every BCD digit of 5 or more, ahead of a left shift
   function automatic logic [DIGITS_W-1:0] bcd_adjust(input logic [DIGITS_W-1:0] d);
      logic [DIGITS_W-1:0] r;
      r = d;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (d[4*i +: 4] >= 4'd5) begin
            r[4*i +: 4] = d[4*i +: 4] + 4'd3;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] glyph(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'd0, d};
      end else begin
         c = CHAR_A + {4'd0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/itdh_front.sv
// Front end: accepts input transactions, classifies radix and prefix,
// and queues them for the back end (two-entry queue). Depends on itdh_pkg.
module itdh_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [itdh_pkg::VALUE_W-1:0]    req_value,
   input  logic                            req_operation,
   input  logic                            req_show_prefix,
   output logic                            job_valid,
   output itdh_pkg::job_type               job,
   input  logic                            job_take
);

   itdh_pkg::job_type queue_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;
   itdh_pkg::job_type classified;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = job_take && job_valid;
   assign job_valid = (count_ff != 2'd0);
   assign job       = queue_ff[rd_ptr_ff];

   // prefix only for a nonzero value in hex mode
   always_comb begin
      classified.value  = req_value;
      classified.hex    = req_operation;
      classified.prefix = req_operation && req_show_prefix && (req_value != '0);
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

FILE: rtl/core/itdh_back.sv
// Back end: binary-to-BCD by double dabble (two bits a cycle) or direct hex
// nibbles, leading-zero skip, prefix and character emission. Depends on itdh_pkg.
module itdh_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  itdh_pkg::job_type job,
   output logic              job_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_char_code,
   output logic              rsp_last
);

   localparam int DW = itdh_pkg::DIGITS_W;
   localparam int VW = itdh_pkg::VALUE_W;

   itdh_pkg::state_type state_ff, state_in;
   logic [DW-1:0]              digits_ff, digits_in;
   logic [VW-1:0]              bin_ff, bin_in;
   logic [itdh_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       prefix_ff, prefix_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 char_ff, char_in;
   logic                       last_ff, last_in;

   logic          out_free;
   logic          top_zero;
   logic          more_left;
   logic [DW-1:0] adj0, adj1;
   logic [DW-1:0] dig1;
   logic [VW-1:0] bin1;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign top_zero  = (digits_ff[DW-1 -: 4] == 4'd0);
   assign more_left = (cnt_ff > itdh_pkg::CNT_W'(1));

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

   // two dependent shift-add-3 steps
   always_comb begin
      adj0 = itdh_pkg::bcd_adjust(digits_ff);
      {dig1, bin1} = {adj0, bin_ff} << 1;
      adj1 = itdh_pkg::bcd_adjust(dig1);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itdh_pkg::ST_IDLE: begin
            if (job_valid) begin
               state_in = job.hex ? itdh_pkg::ST_SKIP : itdh_pkg::ST_DABBLE;
            end
         end
         itdh_pkg::ST_DABBLE: begin
            if (cnt_ff == itdh_pkg::CNT_W'(itdh_pkg::DABBLE_CY - 1)) begin
               state_in = itdh_pkg::ST_SKIP;
            end
         end
         itdh_pkg::ST_SKIP: begin
            if (!(top_zero && more_left)) begin
               state_in = prefix_ff ? itdh_pkg::ST_PREFIX0 : itdh_pkg::ST_EMIT;
            end
         end
         itdh_pkg::ST_PREFIX0: begin
            if (out_free) begin
               state_in = itdh_pkg::ST_PREFIXX;
            end
         end
         itdh_pkg::ST_PREFIXX: begin
            if (out_free) begin
               state_in = itdh_pkg::ST_EMIT;
            end
         end
         itdh_pkg::ST_EMIT: begin
            if (out_free && !more_left) begin
               state_in = itdh_pkg::ST_IDLE;
            end
         end
         default: state_in = itdh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      job_take     = 1'b0;
      digits_in    = digits_ff;
      bin_in       = bin_ff;
      cnt_in       = cnt_ff;
      prefix_in    = prefix_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         itdh_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_take  = 1'b1;
               prefix_in = job.prefix;
               bin_in    = job.value;
               if (job.hex) begin
                  digits_in = {(DW - VW)'(0), job.value};
                  cnt_in    = itdh_pkg::CNT_W'(itdh_pkg::NUM_DIGITS);
               end else begin
                  digits_in = '0;
                  cnt_in    = '0;
               end
            end
         end
         itdh_pkg::ST_DABBLE: begin
            {digits_in, bin_in} = {adj1, bin1} << 1;
            if (cnt_ff == itdh_pkg::CNT_W'(itdh_pkg::DABBLE_CY - 1)) begin
               cnt_in = itdh_pkg::CNT_W'(itdh_pkg::NUM_DIGITS);
            end else begin
               cnt_in = cnt_ff + itdh_pkg::CNT_W'(1);
            end
         end
         itdh_pkg::ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_zero && more_left) begin
               digits_in = digits_ff << 4;
               cnt_in    = cnt_ff - itdh_pkg::CNT_W'(1);
            end
         end
         itdh_pkg::ST_PREFIX0: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = itdh_pkg::CHAR_ZERO;
               last_in      = 1'b0;
            end
         end
         itdh_pkg::ST_PREFIXX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = itdh_pkg::CHAR_X;
               last_in      = 1'b0;
            end
         end
         itdh_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = itdh_pkg::glyph(digits_ff[DW-1 -: 4]);
               last_in      = !more_left;
               digits_in    = digits_ff << 4;
               cnt_in       = cnt_ff - itdh_pkg::CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itdh_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      bin_ff    <= bin_in;
      cnt_ff    <= cnt_in;
      prefix_ff <= prefix_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

endmodule

FILE: rtl/core/integer_to_text_dec_hex.sv
// Top level of the integer-to-text converter (decimal or upper-case hex).
// Instantiates itdh_front and itdh_back; depends on itdh_pkg.
//
// Usage:
//   req channel: req_value (64-bit unsigned), req_operation (0 decimal,
//   1 hex), req_show_prefix (prepend "0x" for a nonzero hex value). A
//   transaction is taken when req_valid is high and req_stall is low.
//   rsp channel: one ASCII character per transaction on rsp_char_code,
//   most significant first, no leading zeros; rsp_last marks the final one.
//   Zero always gives the single character '0'.
// Timing: a two-entry queue buffers requests ahead of the converter.
//   Decimal: double dabble (two bits per cycle), then the leading-zero skip,
//   then one character at a time. Hex: the same skip and emission, with the
//   "0x" prefix emitted first when it is asked for. The converter takes the
//   next value from the queue only after the last character of the current one.
// Reset clears the queue, the sequencer and the output valid flag.
// rsp_stall holds the current character and pauses character emission; the
// queue keeps accepting until it is full, then req_stall rises.
module integer_to_text_dec_hex (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value,
   input  logic        req_operation,
   input  logic        req_show_prefix,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last
);

   logic              job_valid;
   logic              job_take;
   itdh_pkg::job_type job;

   itdh_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_operation   (req_operation),
      .req_show_prefix (req_show_prefix),
      .job_valid       (job_valid),
      .job             (job),
      .job_take        (job_take)
   );

   itdh_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .job_take      (job_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: sim/integer_to_text_dec_hex_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_text_dec_hex: decimal and hex text, prefix and zero.
// Depends on itdh_pkg and the integer_to_text_dec_hex RTL; needs no other files.
module integer_to_text_dec_hex_tb;

   localparam logic OP_DEC         = 1'b0;
   localparam logic OP_HEX         = 1'b1;
   localparam int   RANDOM_ITEMS   = 253;
   localparam int   CALM_ITEMS     = 40;
   localparam int   QUIET_LIMIT    = 4000;
   localparam int   TAIL_CYCLES    = 80;
   localparam int   LONG_HOLD      = 300;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } text_char_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [63:0] req_value       = '0;
   logic        req_operation   = OP_DEC;
   logic        req_show_prefix = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [7:0]  rsp_char_code;
   logic        rsp_last;

   text_char_type expected_chars[$];
   int          mismatch_count  = 0;
   bit          req_idle_on     = 1'b1;
   bit          rsp_idle_on     = 1'b1;
   int          rsp_hold_request = 0;

   integer_to_text_dec_hex dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_operation   (req_operation),
      .req_show_prefix (req_show_prefix),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_code   (rsp_char_code),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Append the characters that one value must produce, most significant first.
   function automatic void queue_text(input logic [63:0] v, input logic hex, input logic pfx);
      logic [7:0]  chars[$];
      logic [63:0] rest;
      logic [3:0]  nib;
      rest = v;
      if (v == 64'd0) begin
         chars.push_front(itdh_pkg::CHAR_ZERO);
      end else if (hex == OP_HEX) begin
         while (rest != 64'd0) begin
            nib = rest[3:0];
            if (nib < 4'd10) begin
               chars.push_front(itdh_pkg::CHAR_ZERO + {4'd0, nib});
            end else begin
               chars.push_front(itdh_pkg::CHAR_A + {4'd0, nib} - 8'd10);
            end
            rest = rest >> 4;
         end
         if (pfx) begin
            chars.push_front(itdh_pkg::CHAR_X);
            chars.push_front(itdh_pkg::CHAR_ZERO);
         end
      end else begin
         while (rest != 64'd0) begin
            chars.push_front(itdh_pkg::CHAR_ZERO + 8'(rest % 64'd10));
            rest = rest / 64'd10;
         end
      end
      foreach (chars[i]) begin
         expected_chars.push_back('{code: chars[i], last: (i == chars.size() - 1)});
      end
   endfunction

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         2: v = 64'($urandom_range(0, 20));
         3: v = 64'd1 << $urandom_range(0, 63);
         default: v = v >> $urandom_range(0, 63);
      endcase
      return v;
   endfunction

   // Offer one transaction, hold it until accepted, then record what it must produce.
   task automatic send_value(input logic [63:0] v, input logic op, input logic pfx);
      int gap;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_value       <= v;
      req_operation   <= op;
      req_show_prefix <= pfx;
      do @(posedge clock); while (req_stall);
      queue_text(v, op, pfx);
   endtask

   task automatic test_zero();
      send_value(64'd0, OP_DEC, 1'b0);
      send_value(64'd0, OP_DEC, 1'b1);
      send_value(64'd0, OP_HEX, 1'b0);
      send_value(64'd0, OP_HEX, 1'b1);
   endtask

   task automatic test_decimal_extremes();
      send_value(64'd1, OP_DEC, 1'b0);
      send_value(64'd9, OP_DEC, 1'b1);
      send_value(64'd10, OP_DEC, 1'b0);
      send_value(64'd10000000000000000000, OP_DEC, 1'b1);
      send_value(64'd9999999999999999999, OP_DEC, 1'b0);
      send_value('1, OP_DEC, 1'b1);
      send_value(64'h8000_0000_0000_0000, OP_DEC, 1'b0);
   endtask

   task automatic test_hex_extremes();
      send_value(64'h1, OP_HEX, 1'b1);
      send_value(64'hF, OP_HEX, 1'b0);
      send_value(64'h10, OP_HEX, 1'b1);
      send_value(64'hABCD_EF01_2345_6789, OP_HEX, 1'b0);
      send_value(64'h1234_5678_9ABC_DEF0, OP_HEX, 1'b1);
      send_value('1, OP_HEX, 1'b1);
      send_value('1, OP_HEX, 1'b0);
      send_value(64'h8000_0000_0000_0000, OP_HEX, 1'b1);
   endtask

   // Stall the result side for a long stretch while requests keep coming.
   task automatic test_backpressure();
      rsp_hold_request = LONG_HOLD;
      for (int i = 0; i < 8; i++) begin
         send_value(random_value(), 1'($urandom), 1'($urandom));
      end
   endtask

   task automatic test_random();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - CALM_ITEMS) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         send_value(random_value(), 1'($urandom), 1'($urandom));
      end
   endtask

   // Result-side stall: random bursts, plus the long hold when one is requested.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            hold_left = $urandom_range(1, 16) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character: expected none, actual code %h last %b",
                     $time, rsp_char_code, rsp_last);
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_char_code !== want.code) begin
               $display("%0t: char_code mismatch: expected %h, actual %h",
                        $time, want.code, rsp_char_code);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last mismatch: expected %b, actual %b",
                        $time, want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run if no transaction moves on either side for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_zero();
      test_decimal_extremes();
      test_hex_extremes();
      test_backpressure();
      test_random();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
